FILE: src/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared widths, fixed-point constants and the arctangent table for the
// differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int POS_W   = 32;   // Q16.16 wheel positions and pose
  localparam int HEAD_W  = 31;   // Q3.28 heading
  localparam int IWB_W   = 24;   // Q8.16 inverse wheel base
  localparam int CRD_W   = 42;   // CORDIC x/y with eight guard bits
  localparam int ANG_W   = 32;   // CORDIC residual angle
  localparam int STEP_W  = 5;    // step counter, values 0 to 31
  localparam int GAIN_W  = 30;   // bits of the CORDIC gain
  localparam int RED_W   = 55;   // heading reduction remainder

  localparam logic [IWB_W-1:0]  IWB_RESET = 24'd242726;
  localparam logic signed [31:0] PI_Q      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
  localparam logic [GAIN_W-1:0] GAIN_Q30  = 30'd652032874;
  // two pi shifted to the top of the reduction range
  localparam logic [RED_W-1:0]  MOD_INIT  = 55'd1686629713 << 23;
  localparam int RED_STEPS = 24;

  // atan(2^-i) in Q3.28, rounded
  function automatic logic [27:0] atan_q28(input logic [STEP_W-1:0] i);
    logic [27:0] v;
    begin
      case (i)
        5'd0:  v = 28'd210828714;
        5'd1:  v = 28'd124459457;
        5'd2:  v = 28'd65760959;
        5'd3:  v = 28'd33381290;
        5'd4:  v = 28'd16755422;
        5'd5:  v = 28'd8385879;
        5'd6:  v = 28'd4193963;
        5'd7:  v = 28'd2097109;
        5'd8:  v = 28'd1048571;
        5'd9:  v = 28'd524287;
        5'd10: v = 28'd262144;
        5'd11: v = 28'd131072;
        5'd12: v = 28'd65536;
        5'd13: v = 28'd32768;
        5'd14: v = 28'd16384;
        5'd15: v = 28'd8192;
        5'd16: v = 28'd4096;
        5'd17: v = 28'd2048;
        5'd18: v = 28'd1024;
        5'd19: v = 28'd512;
        5'd20: v = 28'd256;
        5'd21: v = 28'd128;
        5'd22: v = 28'd64;
        5'd23: v = 28'd32;
        5'd24: v = 28'd16;
        5'd25: v = 28'd8;
        5'd26: v = 28'd4;
        5'd27: v = 28'd2;
        5'd28: v = 28'd1;
        default: v = 28'd0;
      endcase
      return v;
    end
  endfunction

endpackage

FILE: src/ddo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_sample_if / ddo_pose_if
// Valid/ready channels carrying wheel samples in and pose results out.
// ----------------------------------------------------------------------------
interface ddo_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddo_pkg::POS_W-1:0]    left_position;
  logic signed [ddo_pkg::POS_W-1:0]    right_position;
  modport source (output valid, output left_position, output right_position, input ready);
  modport sink   (input valid, input left_position, input right_position, output ready);
endinterface

interface ddo_pose_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddo_pkg::POS_W-1:0]    pose_x;
  logic signed [ddo_pkg::POS_W-1:0]    pose_y;
  logic signed [ddo_pkg::HEAD_W-1:0]   heading_out;
  modport source (output valid, output pose_x, output pose_y, output heading_out,
                  input ready);
  modport sink   (input valid, input pose_x, input pose_y, input heading_out,
                  output ready);
endinterface

FILE: src/ddo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per enabled cycle.
// ----------------------------------------------------------------------------
module ddo_cordic (
  input  logic                               clk,
  input  logic                               load,
  input  logic                               step_en,
  input  logic [ddo_pkg::STEP_W-1:0]         step,
  input  logic signed [ddo_pkg::CRD_W-1:0]   x_init,
  input  logic signed [ddo_pkg::ANG_W-1:0]   z_init,
  output logic signed [ddo_pkg::CRD_W-1:0]   x_res,
  output logic signed [ddo_pkg::CRD_W-1:0]   y_res
);

  logic signed [ddo_pkg::CRD_W-1:0] x;
  logic signed [ddo_pkg::CRD_W-1:0] y;
  logic signed [ddo_pkg::ANG_W-1:0] z;
  logic signed [ddo_pkg::CRD_W-1:0] xs;
  logic signed [ddo_pkg::CRD_W-1:0] ys;
  logic signed [ddo_pkg::ANG_W-1:0] at;

  // shifted operands and table angle for this step
  always_comb begin
    xs = x >>> step;
    ys = y >>> step;
    at = $signed({4'd0, ddo_pkg::atan_q28(step)});
  end

  // load the start vector, then turn towards zero residual angle
  always_ff @(posedge clk) begin
    if (load) begin
      x <= x_init;
      y <= '0;
      z <= z_init;
    end else if (step_en) begin
      if (!z[ddo_pkg::ANG_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  assign x_res = x;
  assign y_res = y;

endmodule

FILE: src/differential_drive_odometry.sv
`timescale 1ns / 1ps
// Sequence: bit-serial gain and wheel-base multiplies, a set-up step, then the CORDIC
// alongside the 24-step heading reduction, then the pose update, which holds while an
// earlier result still waits for ready.
// One item at a time: sample.ready is high only in ST_IDLE, so the next transfer is
// taken only after the result is stored; no new sample is taken while one is in work.
// Reset (rst, synchronous): pose, heading, stored positions, primed flag cleared; default iwb.
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry: wheel deltas, CORDIC rotation of mean travel by the heading,
// saturating pose accumulation and wrapped heading update.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  ddo_sample_if.sink                  sample,
  ddo_pose_if.source                  pose,
  input  logic                        cfg_we,
  input  logic [ddo_pkg::IWB_W-1:0]   cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_ROT  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int ROT_CYC = (CORDIC_STEPS > ddo_pkg::RED_STEPS) ? CORDIC_STEPS
                                                                 : ddo_pkg::RED_STEPS;
  localparam logic [ddo_pkg::STEP_W-1:0] ROT_LAST  = ddo_pkg::STEP_W'(ROT_CYC - 1);
  localparam logic [ddo_pkg::STEP_W-1:0] MUL_LAST  = ddo_pkg::STEP_W'(ddo_pkg::GAIN_W - 1);
  localparam logic [ddo_pkg::STEP_W-1:0] CRD_STEPS = ddo_pkg::STEP_W'(CORDIC_STEPS);
  localparam logic [ddo_pkg::STEP_W-1:0] RED_CNT   = ddo_pkg::STEP_W'(ddo_pkg::RED_STEPS);

  logic [2:0]                   state;
  logic [ddo_pkg::STEP_W-1:0]   cnt;
  logic [ddo_pkg::IWB_W-1:0]    iwb;
  logic signed [31:0]           last_left;
  logic signed [31:0]           last_right;
  logic                         primed;
  logic signed [30:0]           heading;
  logic signed [31:0]           x_acc;
  logic signed [31:0]           y_acc;

  // multiply shift registers
  logic signed [62:0]           gm;
  logic signed [62:0]           gacc;
  logic [ddo_pkg::GAIN_W-1:0]   gsh;
  logic signed [57:0]           tm;
  logic signed [57:0]           tacc;
  logic [ddo_pkg::IWB_W-1:0]    ish;
  logic signed [31:0]           angle;

  // heading reduction
  logic [ddo_pkg::RED_W-1:0]    rem;
  logic [ddo_pkg::RED_W-1:0]    modv;

  logic                         out_valid;
  logic signed [31:0]           out_x;
  logic signed [31:0]           out_y;
  logic signed [30:0]           out_h;

  // intake arithmetic
  logic signed [32:0]           dl;
  logic signed [32:0]           dr;
  logic signed [33:0]           wsum;
  logic signed [33:0]           wdiff;
  logic signed [32:0]           travel;
  logic signed [31:0]           h32;
  logic                         fold;
  logic signed [31:0]           angle_next;
  logic signed [32:0]           travel_next;

  // preparation arithmetic
  logic signed [53:0]           turn;
  logic signed [55:0]           hsum;
  logic signed [55:0]           hpos;
  logic signed [ddo_pkg::CRD_W-1:0] x_init;

  // completion arithmetic
  logic signed [ddo_pkg::CRD_W-1:0] x_res;
  logic signed [ddo_pkg::CRD_W-1:0] y_res;
  logic signed [34:0]           xs;
  logic signed [34:0]           ys;
  logic signed [31:0]           x_next;
  logic signed [31:0]           y_next;
  logic signed [31:0]           h_next;

  logic                         accept;
  logic                         crd_load;
  logic                         crd_en;

  assign accept = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);

  // wheel deltas, mean travel, wheel difference and heading fold
  always_comb begin
    if (primed) begin
      dl = 33'(sample.left_position) - 33'(last_left);
      dr = 33'(sample.right_position) - 33'(last_right);
    end else begin
      dl = '0;
      dr = '0;
    end
    wsum   = 34'(dl) + 34'(dr);
    wdiff  = 34'(dr) - 34'(dl);
    travel = wsum[33:1];
    h32    = 32'(heading);
    fold   = 1'b1;
    if (h32 > ddo_pkg::HALF_PI_Q) begin
      angle_next = h32 - ddo_pkg::PI_Q;
    end else if (h32 < -ddo_pkg::HALF_PI_Q) begin
      angle_next = h32 + ddo_pkg::PI_Q;
    end else begin
      angle_next = h32;
      fold       = 1'b0;
    end
    travel_next = fold ? -travel : travel;
  end

  // heading sum shifted to a non-negative value with the same remainder; CORDIC start x
  always_comb begin
    turn   = tacc[57:4];
    hsum   = 56'(heading) + 56'(turn) + 56'(ddo_pkg::PI_Q);
    hpos   = hsum[55] ? hsum + $signed({1'b0, ddo_pkg::MOD_INIT}) : hsum;
    x_init = ddo_pkg::CRD_W'($signed(gacc[62:22]));
  end

  // pose accumulation with saturation, wrapped heading
  always_comb begin
    xs = 35'(x_acc) + 35'(x_res >>> 8);
    ys = 35'(y_acc) + 35'(y_res >>> 8);
    if (xs > 35'sd2147483647)       x_next = 32'sh7fffffff;
    else if (xs < -35'sd2147483648) x_next = 32'sh80000000;
    else                            x_next = xs[31:0];
    if (ys > 35'sd2147483647)       y_next = 32'sh7fffffff;
    else if (ys < -35'sd2147483648) y_next = 32'sh80000000;
    else                            y_next = ys[31:0];
    h_next = $signed({1'b0, rem[30:0]}) - ddo_pkg::PI_Q;
  end

  assign crd_load = (state == ST_PREP);
  assign crd_en   = (state == ST_ROT) && (cnt < CRD_STEPS);

  ddo_cordic u_cordic (
    .clk     (clk),
    .load    (crd_load),
    .step_en (crd_en),
    .step    (cnt),
    .x_init  (x_init),
    .z_init  (angle),
    .x_res   (x_res),
    .y_res   (y_res)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      iwb <= ddo_pkg::IWB_RESET;
    end else if (cfg_we) begin
      iwb <= cfg_data;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      primed     <= 1'b0;
      last_left  <= '0;
      last_right <= '0;
      heading    <= '0;
      x_acc      <= '0;
      y_acc      <= '0;
      out_valid  <= 1'b0;
    end else begin
      // raise a new result, or drop the old one once transferred
      if ((state == ST_DONE) && (!out_valid || pose.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && pose.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_left  <= sample.left_position;
            last_right <= sample.right_position;
            primed     <= 1'b1;
            cnt        <= '0;
            state      <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          cnt   <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          cnt <= cnt + 1'b1;
          if (cnt == ROT_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || pose.ready) begin
            heading   <= h_next[30:0];
            x_acc     <= x_next;
            y_acc     <= y_next;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath: bit-serial multiplies, restoring heading reduction and result register
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          gm    <= 63'(travel_next);
          gacc  <= '0;
          gsh   <= ddo_pkg::GAIN_Q30;
          tm    <= 58'(wdiff);
          tacc  <= '0;
          ish   <= iwb;
          angle <= angle_next;
        end
      end
      ST_MUL: begin
        if (gsh[0]) gacc <= gacc + gm;
        if (ish[0]) tacc <= tacc + tm;
        gm  <= gm <<< 1;
        tm  <= tm <<< 1;
        gsh <= gsh >> 1;
        ish <= ish >> 1;
      end
      ST_PREP: begin
        rem  <= hpos[ddo_pkg::RED_W-1:0];
        modv <= ddo_pkg::MOD_INIT;
      end
      ST_ROT: begin
        if (cnt < RED_CNT) begin
          if (rem >= modv) rem <= rem - modv;
          modv <= modv >> 1;
        end
      end
      ST_DONE: begin
        if (!out_valid || pose.ready) begin
          out_x <= x_next;
          out_y <= y_next;
          out_h <= h_next[30:0];
        end
      end
      default: begin
        gacc <= gacc;
      end
    endcase
  end

  assign pose.valid       = out_valid;
  assign pose.pose_x      = out_x;
  assign pose.pose_y      = out_y;
  assign pose.heading_out = out_h;

`ifndef SYNTH
  // a transfer always starts the multiply phase
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_MUL)
    else $error("transfer did not start the multiply phase");

  // stored heading stays inside minus pi to pi
  a_head: assert property (@(posedge clk) disable iff (rst)
    (32'(heading) >= -ddo_pkg::PI_Q) && (32'(heading) < ddo_pkg::PI_Q))
    else $error("heading outside wrap range");

  // a new result only appears from the completion step
  a_res: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion");
`endif

endmodule

FILE: sim/differential_drive_odometry_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_tb
// Drives wheel position samples through the odometry block with random gaps
// on both channels and checks every pose against an in-bench fixed-point
// predictor of the delta, CORDIC rotation, saturation and heading wrap.
// ----------------------------------------------------------------------------
module differential_drive_odometry_tb;

  localparam int  STEPS       = 16;
  localparam int  LATENCY     = 60;
  localparam int  STALL_LIMIT = 20000;
  localparam longint PI_L      = 64'sd843314857;
  localparam longint TWO_PI_L  = 64'sd1686629713;
  localparam longint HALF_PI_L = 64'sd421657428;
  localparam longint GAIN_L    = 64'sd652032874;
  localparam int  GUARD       = 8;

  typedef struct packed {
    logic signed [ddo_pkg::POS_W-1:0]  x;
    logic signed [ddo_pkg::POS_W-1:0]  y;
    logic signed [ddo_pkg::HEAD_W-1:0] heading;
  } pose_t;

  // Odometry predictor and queue of expected poses
  class odometry_scoreboard;
    logic [ddo_pkg::IWB_W-1:0] iwb;
    longint prev_left, prev_right, heading_q, x_q, y_q;
    bit     primed;
    pose_t  pending_poses[$];
    int     errors;

    function void clear();
      iwb = ddo_pkg::IWB_RESET;
      prev_left = 0; prev_right = 0; heading_q = 0; x_q = 0; y_q = 0;
      primed = 0;
    endfunction

    function longint saturate(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Note an accepted sample and queue the pose it produces
    function void note_sample(logic signed [ddo_pkg::POS_W-1:0] l,
                              logic signed [ddo_pkg::POS_W-1:0] r);
      longint dl, dr, travel, turn, ang, cx, cy, xs, ys, h;
      pose_t p;
      dl = 0; dr = 0;
      if (primed) begin
        dl = longint'(l) - prev_left;
        dr = longint'(r) - prev_right;
      end
      prev_left = l; prev_right = r; primed = 1;
      travel = (dl + dr) >>> 1;
      turn = ((dr - dl) * longint'({40'd0, iwb})) >>> 4;
      // fold the heading into the CORDIC range, then rotate
      ang = heading_q;
      if (ang > HALF_PI_L) begin
        travel = -travel; ang -= PI_L;
      end else if (ang < -HALF_PI_L) begin
        travel = -travel; ang += PI_L;
      end
      cx = (travel * GAIN_L) >>> (30 - GUARD);
      cy = 0;
      for (int i = 0; i < STEPS; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (ang >= 0) begin
          cx -= ys; cy += xs;
          ang -= longint'(ddo_pkg::atan_q28(ddo_pkg::STEP_W'(i)));
        end else begin
          cx += ys; cy -= xs;
          ang += longint'(ddo_pkg::atan_q28(ddo_pkg::STEP_W'(i)));
        end
      end
      h = (heading_q + turn + PI_L) % TWO_PI_L;
      if (h < 0) h += TWO_PI_L;
      heading_q = h - PI_L;
      x_q = saturate(x_q + (cx >>> GUARD));
      y_q = saturate(y_q + (cy >>> GUARD));
      p.x = x_q[31:0]; p.y = y_q[31:0]; p.heading = heading_q[30:0];
      pending_poses = {pending_poses, p};
    endfunction

    task report(string what, longint want, longint got);
      errors++;
      $display("mismatch %s: expected %0d got %0d", what, want, got);
    endtask

    task check_pose(pose_t got);
      pose_t want;
      if (pending_poses.size() == 0) begin
        report("unexpected pose", 0, got.x);
        return;
      end
      want = pending_poses.pop_front();
      if (got.x !== want.x) report("pose_x", want.x, got.x);
      if (got.y !== want.y) report("pose_y", want.y, got.y);
      if (got.heading !== want.heading)
        report("heading_out", longint'(want.heading), longint'(got.heading));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [ddo_pkg::IWB_W-1:0] cfg_data = '0;
  ddo_sample_if sample_ch ();
  ddo_pose_if   pose_ch ();

  odometry_scoreboard board;
  int  idle_cycles;
  bit  hold_off;
  bit  sending_done;

  differential_drive_odometry #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst(rst), .sample(sample_ch.sink), .pose(pose_ch.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    sample_ch.valid = 0;
    sample_ch.left_position = '0;
    sample_ch.right_position = '0;
    pose_ch.ready = 0;
  end

  // Sample transfers on both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready)
        board.note_sample(sample_ch.left_position, sample_ch.right_position);
      if (pose_ch.valid && pose_ch.ready)
        board.check_pose({pose_ch.pose_x, pose_ch.pose_y, pose_ch.heading_out});
      if ((sample_ch.valid && sample_ch.ready) || (pose_ch.valid && pose_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("differential_drive_odometry_tb NOT OK");
      $finish;
    end
  end

  // Result side: random ready gaps, or a long hold-off on request
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        pose_ch.ready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        pose_ch.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      pose_ch.ready <= 1;
      @(posedge clk);
      while (!(pose_ch.valid && pose_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_sample(logic [31:0] l, logic [31:0] r, bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      sample_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid <= 1;
    sample_ch.left_position <= l;
    sample_ch.right_position <= r;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    sample_ch.valid <= 0;
    while (board.pending_poses.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_iwb(logic [ddo_pkg::IWB_W-1:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    board.iwb = v;
  endtask

  // Random walk of wheel positions with occasional jumps and noise
  task automatic random_phase(int count, bit no_gaps);
    logic [31:0] l, r;
    l = $urandom; r = $urandom;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: begin l = $urandom; r = $urandom; end
        1: begin l = l + $urandom_range(0, 1000000); r = r - $urandom_range(0, 1000000); end
        default: begin
          l = l + $signed($urandom_range(0, 400000)) - 200000;
          r = r + $signed($urandom_range(0, 400000)) - 200000;
        end
      endcase
      send_sample(l, r, no_gaps);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    idle_cycles = 0;
    hold_off = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: first sample primes, extremes, wraps, straight and turning runs
    send_sample(32'h7fff_ffff, 32'h8000_0000, 0);
    send_sample(32'h8000_0000, 32'h7fff_ffff, 0);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 0);
    send_sample(32'h0000_0000, 32'hffff_ffff, 0);
    send_sample(32'hffff_ffff, 32'h0000_0000, 0);
    for (int k = 0; k < 8; k++)
      send_sample(32'h4000_0000 * (k % 2) + k * 32'h1000_0000,
                  32'h7000_0000 + k * 32'h1000_0000, 0);
    // drive the pose to saturation in one direction
    for (int k = 0; k < 6; k++)
      send_sample(k * 32'h3fff_ffff, k * 32'h3fff_ffff, 0);
    drain();

    // Register extremes and random settings, with a long receiver hold-off
    write_iwb('0);
    hold_off = 1;
    random_phase(150, 1);
    drain();
    write_iwb({ddo_pkg::IWB_W{1'b1}});
    random_phase(150, 0);
    drain();
    write_iwb(24'd1);
    random_phase(100, 0);
    drain();
    for (int p = 0; p < 8; p++) begin
      write_iwb(ddo_pkg::IWB_W'($urandom_range(0, 24'hffffff)));
      random_phase(100, p % 3 == 0);
      drain();
    end
    write_iwb(ddo_pkg::IWB_RESET);
    random_phase(330, 0);
    drain();

    if (board.errors == 0 && board.pending_poses.size() == 0)
      $display("differential_drive_odometry_tb OK");
    else
      $display("differential_drive_odometry_tb NOT OK");
    $finish;
  end

endmodule
